/* rtl/core/csv_byte_stream_parser_macros.svh */
// Assertion macros used by the top level of the CSV byte stream parser RTL.
`ifndef CSV_BYTE_STREAM_PARSER_MACROS_SVH
`define CSV_BYTE_STREAM_PARSER_MACROS_SVH

// Check a property on every clk edge outside of reset.
`define CSVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clk edge, reset cycles included.
`define CSVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/csvp_pkg.sv */
// Types and constants of the CSV byte stream parser.
`default_nettype none

package csvp_pkg;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int FIELD_W     = 6;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int LINE_LIMIT_W   = 11;
  localparam int COLUMN_LIMIT_W = 7;

  localparam int MAX_COLUMNS  = 64;
  localparam int COLUMN_CEIL  = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;
  localparam int COLUMN_RESET = 64;
  localparam int LINE_RESET   = 1024;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_LIMIT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_LIMIT = 1'd1;

  localparam logic [KIND_W-1:0] EV_DATA      = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIELD     = 3'd1;
  localparam logic [KIND_W-1:0] EV_RECORD    = 3'd2;
  localparam logic [KIND_W-1:0] EV_QUOTE_ERR = 3'd3;
  localparam logic [KIND_W-1:0] EV_WIDE_ERR  = 3'd4;
  localparam logic [KIND_W-1:0] EV_COLS_ERR  = 3'd5;

  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_QUOTED = 3'd1,
    MODE_QMARK  = 3'd2,
    MODE_CLOSED = 3'd3,
    MODE_HALT   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              stream_end;
  } text_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [FIELD_W-1:0] field_index;
  } evt_item_t;

  typedef struct packed {
    logic               emit;
    evt_item_t          evt;
    mode_t              mode_next;
    logic [FIELD_W-1:0] field_next;
  } step_t;

endpackage

`default_nettype wire

/* rtl/core/csvp_step.sv */
// Per-byte parse step: next mode, field, line count and the event to emit.
`default_nettype none

module csvp_step #(
  parameter int CW = 10
) (
  input  csvp_pkg::text_item_t            item,
  input  csvp_pkg::mode_t                 mode,
  input  logic [csvp_pkg::FIELD_W-1:0]    field,
  input  logic [CW-1:0]                   count,
  input  logic [CW-1:0]                   line_cap,
  input  logic [csvp_pkg::FIELD_W-1:0]    col_cap,
  output csvp_pkg::step_t                 res,
  output logic [CW-1:0]                   count_next
);

  logic [csvp_pkg::BYTE_W-1:0] c;
  logic is_lf;
  logic is_comma;
  logic is_quote;
  logic is_blank;
  logic do_comma;
  logic do_newline;
  logic do_quote_err;

  assign c        = item.byte_in;
  assign is_lf    = (c == csvp_pkg::CH_LF);
  assign is_comma = (c == csvp_pkg::CH_COMMA);
  assign is_quote = (c == csvp_pkg::CH_QUOTE);
  assign is_blank = c inside {csvp_pkg::CH_SPACE, csvp_pkg::CH_TAB};

  always_comb begin
    res                 = '0;
    res.evt.field_index = field;
    res.mode_next       = mode;
    res.field_next      = field;
    count_next          = count;
    do_comma            = 1'b0;
    do_newline          = 1'b0;
    do_quote_err        = 1'b0;

    if (mode == csvp_pkg::MODE_HALT) begin
      res.emit = 1'b0;
    end else if (item.stream_end) begin
      if (mode == csvp_pkg::MODE_QUOTED) begin
        do_quote_err = 1'b1;
      end else begin
        res.emit           = (count != '0);
        res.evt.event_kind = csvp_pkg::EV_RECORD;
        res.mode_next      = csvp_pkg::MODE_PLAIN;
        res.field_next     = '0;
        count_next         = '0;
      end
    end else if (!is_lf && (count >= line_cap)) begin
      res.emit           = 1'b1;
      res.evt.event_kind = csvp_pkg::EV_WIDE_ERR;
      res.mode_next      = csvp_pkg::MODE_HALT;
    end else begin
      if (!is_lf) begin
        count_next = count + 1'b1;
      end
      case (mode)
        csvp_pkg::MODE_PLAIN: begin
          if (is_comma) begin
            do_comma = 1'b1;
          end else if (is_lf) begin
            do_newline = 1'b1;
          end else if (is_quote) begin
            res.mode_next = csvp_pkg::MODE_QUOTED;
          end else begin
            res.emit           = 1'b1;
            res.evt.event_kind = csvp_pkg::EV_DATA;
            res.evt.data_byte  = c;
          end
        end
        csvp_pkg::MODE_QUOTED: begin
          if (is_quote) begin
            res.mode_next = csvp_pkg::MODE_QMARK;
          end else if (is_lf) begin
            do_quote_err = 1'b1;
          end else begin
            res.emit           = 1'b1;
            res.evt.event_kind = csvp_pkg::EV_DATA;
            res.evt.data_byte  = c;
          end
        end
        default: begin
          if ((mode == csvp_pkg::MODE_QMARK) && is_quote) begin
            res.mode_next      = csvp_pkg::MODE_QUOTED;
            res.emit           = 1'b1;
            res.evt.event_kind = csvp_pkg::EV_DATA;
            res.evt.data_byte  = c;
          end else if (is_blank) begin
            res.mode_next = csvp_pkg::MODE_CLOSED;
          end else if (is_comma) begin
            do_comma = 1'b1;
          end else if (is_lf) begin
            do_newline = 1'b1;
          end else begin
            do_quote_err = 1'b1;
          end
        end
      endcase
    end

    if (do_comma) begin
      res.emit = 1'b1;
      if (field >= col_cap) begin
        res.evt.event_kind = csvp_pkg::EV_COLS_ERR;
        res.mode_next      = csvp_pkg::MODE_HALT;
      end else begin
        res.evt.event_kind = csvp_pkg::EV_FIELD;
        res.mode_next      = csvp_pkg::MODE_PLAIN;
        res.field_next     = field + 1'b1;
      end
    end
    if (do_newline) begin
      res.emit           = 1'b1;
      res.evt.event_kind = csvp_pkg::EV_RECORD;
      res.mode_next      = csvp_pkg::MODE_PLAIN;
      res.field_next     = '0;
      count_next         = '0;
    end
    if (do_quote_err) begin
      res.emit           = 1'b1;
      res.evt.event_kind = csvp_pkg::EV_QUOTE_ERR;
      res.mode_next      = csvp_pkg::MODE_HALT;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/csv_byte_stream_parser.sv */
// Top level of the streaming CSV byte parser.
//
// Text channel (text_valid, text_stall, text_item): one byte per item, or an
// end-of-stream mark when stream_end is set.
// Event channel (evt_valid, evt_stall, evt_item): at most one event per text
// item: a data byte with its field index, a field end, a record end, or an
// error (quote, line too wide, too many columns).
// Configuration: cfg_write with cfg_index and cfg_data sets line_limit (0)
// or column_limit (1); write only while no item is in flight.
// Path: a text item is taken into the input register, and its event is
// loaded into the event register from the combinational parse step between
// the two. Throughput: one item per cycle while the receiver does not stall.
// Reset clears all parse state, restores the default limits and empties
// both registers. An error halts the parser until the next reset; later
// items are taken and dropped.
// When the receiver stalls, the event register holds, one more item may sit
// in the input register, and text_stall rises while that item waits.
`default_nettype none

module csv_byte_stream_parser #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                text_valid,
  output logic                                text_stall,
  input  csvp_pkg::text_item_t                text_item,
  output logic                                evt_valid,
  input  logic                                evt_stall,
  output csvp_pkg::evt_item_t                 evt_item,
  input  logic                                cfg_write,
  input  logic [csvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [csvp_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "csv_byte_stream_parser_macros.svh"

  localparam int CW         = $clog2(LINE_BYTES);
  localparam int LINE_CEIL  = LINE_BYTES;
  localparam int LINE_START = ((csvp_pkg::LINE_RESET < LINE_CEIL) ?
                               csvp_pkg::LINE_RESET : LINE_CEIL) - 2;
  localparam int COL_START  = ((csvp_pkg::COLUMN_RESET < csvp_pkg::COLUMN_CEIL) ?
                               csvp_pkg::COLUMN_RESET : csvp_pkg::COLUMN_CEIL) - 1;

  logic                               s1_valid;
  csvp_pkg::text_item_t               s1_item;
  csvp_pkg::mode_t                    mode;
  logic [csvp_pkg::FIELD_W-1:0]       field;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      line_cap;
  logic [csvp_pkg::FIELD_W-1:0]       col_cap;
  logic [CW-1:0]                      line_cap_next;
  logic [csvp_pkg::FIELD_W-1:0]       col_cap_next;
  logic [csvp_pkg::LINE_LIMIT_W-1:0]  line_val;
  logic [csvp_pkg::COLUMN_LIMIT_W-1:0] col_val;
  csvp_pkg::step_t                    res;
  logic [CW-1:0]                      count_next;
  logic                               out_free;
  logic                               s1_fire;
  logic                               evt_load;

  assign out_free   = !evt_valid || !evt_stall;
  assign s1_fire    = s1_valid && out_free;
  assign text_stall = s1_valid && !out_free;
  assign evt_load   = s1_fire && res.emit;

  // Clamp the limits once, at write time.
  assign line_val = cfg_data[csvp_pkg::LINE_LIMIT_W-1:0];
  assign col_val  = cfg_data[csvp_pkg::COLUMN_LIMIT_W-1:0];

  always_comb begin
    if (32'(line_val) < 32'd2) begin
      line_cap_next = '0;
    end else if (32'(line_val) >= 32'(LINE_CEIL)) begin
      line_cap_next = CW'(LINE_CEIL - 2);
    end else begin
      line_cap_next = CW'(32'(line_val) - 32'd2);
    end
    if (col_val == '0) begin
      col_cap_next = '0;
    end else if (32'(col_val) >= 32'(csvp_pkg::COLUMN_CEIL)) begin
      col_cap_next = csvp_pkg::FIELD_W'(csvp_pkg::COLUMN_CEIL - 1);
    end else begin
      col_cap_next = csvp_pkg::FIELD_W'(32'(col_val) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cap <= CW'(LINE_START);
      col_cap  <= csvp_pkg::FIELD_W'(COL_START);
    end else if (cfg_write) begin
      if (cfg_index == csvp_pkg::REG_LINE_LIMIT) begin
        line_cap <= line_cap_next;
      end
      if (cfg_index == csvp_pkg::REG_COLUMN_LIMIT) begin
        col_cap <= col_cap_next;
      end
    end
  end

  csvp_step #(
    .CW(CW)
  ) u_step (
    .item       (s1_item),
    .mode       (mode),
    .field      (field),
    .count      (count),
    .line_cap   (line_cap),
    .col_cap    (col_cap),
    .res        (res),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_valid && !text_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_item <= text_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= csvp_pkg::MODE_PLAIN;
      field <= '0;
      count <= '0;
    end else if (s1_fire) begin
      mode  <= res.mode_next;
      field <= res.field_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (out_free) begin
      evt_valid <= evt_load;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_load) begin
      evt_item <= res.evt;
    end
  end

  `CSVP_ASSERT(a_halt_sticky, mode == csvp_pkg::MODE_HALT |=> mode == csvp_pkg::MODE_HALT, "halt left without reset")
  `CSVP_ASSERT(a_err_halts, (evt_load && (res.evt.event_kind == csvp_pkg::EV_QUOTE_ERR || res.evt.event_kind == csvp_pkg::EV_WIDE_ERR || res.evt.event_kind == csvp_pkg::EV_COLS_ERR)) |=> mode == csvp_pkg::MODE_HALT, "error without halt")
  `CSVP_ASSERT(a_s1_hold, (s1_valid && !out_free) |=> (s1_valid && $stable(s1_item)), "waiting item lost")
  `CSVP_ASSERT_ALWAYS(a_reset_clear, rst |=> (mode == csvp_pkg::MODE_PLAIN && !evt_valid && !s1_valid), "reset did not clear")

endmodule

`default_nettype wire
